// ----- sv/tempo_gate_clock_macros.svh -----
// ---------------------------------------------------------------------------
// tempo_gate_clock assertion macros
// Shared concurrent assertion forms for the tempo gate clock block.
// ---------------------------------------------------------------------------
`ifndef TEMPO_GATE_CLOCK_MACROS_SVH
`define TEMPO_GATE_CLOCK_MACROS_SVH

// Condition holds at every edge out of reset
`define TGC_ASSERT_ALWAYS(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) else $error(msg);

// Antecedent at one edge implies consequent at the next
`define TGC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/tgc_pkg.sv -----
// ---------------------------------------------------------------------------
// tgc_pkg
// Types, widths and constants shared by the tempo gate clock modules.
// ---------------------------------------------------------------------------
package tgc_pkg;

    // Parameter defaults
    localparam int BEAT_FRAC_BITS_DEF = 16;
    localparam int BPM_FRAC_BITS_DEF  = 8;
    localparam int POS_WIDTH_DEF      = 25;

    // Fixed field widths
    localparam int SR_W      = 18;
    localparam int BPM_W     = 17;
    localparam int DIV_W     = 7;
    localparam int MODE_W    = 2;
    localparam int BPB_W     = 6;
    localparam int HB_W      = 21;
    localparam int BEAT_IDX_W = 5;
    localparam int CFG_W     = 18;
    localparam int CFG_IDX_W = 2;
    localparam int AV_W      = BPM_W + DIV_W;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SAMPLE_RATE  = 2'd0,
        REG_INTERNAL_BPM = 2'd1,
        REG_DIVISION     = 2'd2,
        REG_SYNC_MODE    = 2'd3
    } reg_index_t;

    // Divisions worked per word, in order
    typedef enum logic [1:0] {
        OP_PERIOD_OLD = 2'd0,
        OP_SYNC_OLD   = 2'd1,
        OP_PERIOD_NEW = 2'd2,
        OP_SYNC_NEW   = 2'd3
    } div_op_t;

    localparam logic [MODE_W-1:0] MODE_FREE = 2'd0;

    // Reset values
    localparam logic [SR_W-1:0]   SR_RESET     = 18'd48000;
    localparam logic [BPM_W-1:0]  IBPM_RESET   = 17'd30720;
    localparam logic [DIV_W-1:0]  DIV_RESET    = 7'd2;
    localparam logic [MODE_W-1:0] MODE_RESET   = 2'd1;
    localparam logic [BPM_W-1:0]  ABPM_RESET   = 17'd30720;

    // Arithmetic constants
    localparam int BPM_TOL        = 9;
    localparam int BPM_TOL_SCALE  = 1000;
    localparam int EOB_HI_NUM     = 99;
    localparam int EOB_HI_DEN     = 100;
    localparam int EOB_LO_DEN     = 10;
    localparam int SR_BEAT_MULT   = 60;
    localparam int SR_PERIOD_MULT = 120;

    // Controller to datapath commands
    typedef struct packed {
        logic    capture;
        logic    prep;
        logic    load;
        div_op_t op;
        logic    store;
        logic    finish;
    } tgc_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic div_busy;
    } tgc_status_t;

endpackage

// ----- sv/tgc_div.sv -----
// ---------------------------------------------------------------------------
// tgc_div
// Restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module tgc_div #(
    parameter int NUM_W = 33,
    parameter int DEN_W = 24
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             busy,
    output logic [NUM_W-1:0] quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             busy_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [NUM_W-1:0] quo_reg;
    logic [DEN_W-1:0] den_reg;

    logic [DEN_W:0]   rem_sh;
    logic [DEN_W:0]   rem_sub;
    logic             ge;

    // Trial subtract
    always_comb
    begin
        rem_sh  = {rem_reg, quo_reg[NUM_W-1]};
        rem_sub = rem_sh - {1'b0, den_reg};
        ge      = rem_sh >= {1'b0, den_reg};
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(NUM_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
                busy_reg <= 1'b0;
        end
    end

    // Shift registers
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= num;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
            quo_reg <= {quo_reg[NUM_W-2:0], ge};
        end
    end

    assign busy = busy_reg;
    assign quot = quo_reg;

endmodule

// ----- sv/tgc_datapath.sv -----
// ---------------------------------------------------------------------------
// tgc_datapath
// Transport state, tempo tracking, division operands and gate logic.
// ---------------------------------------------------------------------------
module tgc_datapath #(
    parameter int BEAT_FRAC_BITS = tgc_pkg::BEAT_FRAC_BITS_DEF,
    parameter int BPM_FRAC_BITS  = tgc_pkg::BPM_FRAC_BITS_DEF,
    parameter int POS_WIDTH      = tgc_pkg::POS_WIDTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  tgc_pkg::tgc_cmd_t                  cmd,
    output tgc_pkg::tgc_status_t               status,
    input  logic                               wr_en,
    input  logic [tgc_pkg::CFG_IDX_W-1:0]      wr_index,
    input  logic [tgc_pkg::CFG_W-1:0]          wr_data,
    input  logic                               playing,
    input  logic [tgc_pkg::BPB_W-1:0]          beats_per_bar,
    input  logic [tgc_pkg::HB_W-1:0]           host_bar_beat,
    input  logic [tgc_pkg::BPM_W-1:0]          host_bpm,
    input  logic                               close_gate,
    input  logic                               clear_trigger,
    output logic                               gate,
    output logic                               gate_start,
    output logic [POS_WIDTH-1:0]               position,
    output logic [POS_WIDTH-1:0]               period
);

    localparam int SR_W  = tgc_pkg::SR_W;
    localparam int BPM_W = tgc_pkg::BPM_W;
    localparam int DIV_W = tgc_pkg::DIV_W;
    localparam int HB_W  = tgc_pkg::HB_W;
    localparam int AV_W  = tgc_pkg::AV_W;
    localparam int BI_W  = tgc_pkg::BEAT_IDX_W;
    localparam int T_W   = BEAT_FRAC_BITS + 1;
    localparam int G_W   = SR_W + 6 + BPM_FRAC_BITS;
    localparam int NUM_W = SR_W + 7 + BPM_FRAC_BITS;
    localparam int BC_W  = (HB_W > BEAT_FRAC_BITS ? HB_W : BEAT_FRAC_BITS) + 8;
    localparam int DF_W  = BPM_W + 10 + BPM_FRAC_BITS;
    localparam int QX_W  = (NUM_W > POS_WIDTH ? NUM_W : POS_WIDTH) + 1;
    localparam logic [POS_WIDTH-1:0] POS_MAX = '1;

    // Configuration
    logic [SR_W-1:0]           sample_rate_reg;
    logic [BPM_W-1:0]          internal_bpm_reg;
    logic [DIV_W-1:0]          division_reg;
    logic [tgc_pkg::MODE_W-1:0] sync_mode_reg;

    // Captured word
    logic                      in_playing_reg;
    logic [tgc_pkg::BPB_W-1:0] in_bpb_reg;
    logic [HB_W-1:0]           in_hb_reg;
    logic [BPM_W-1:0]          in_hbpm_reg;
    logic                      in_close_reg;
    logic                      in_clear_reg;

    // Block state
    logic [POS_WIDTH-1:0]      position_reg;
    logic                      trigger_reg;
    logic                      gate_reg;
    logic                      eob_reg;
    logic                      was_playing_reg;
    logic [BI_W-1:0]           last_beat_reg;
    logic                      bar_par_reg;
    logic [BPM_W-1:0]          active_bpm_reg;
    logic [BPM_W-1:0]          last_host_bpm_reg;
    logic [tgc_pkg::MODE_W-1:0] last_mode_reg;

    // Operands and results of the divisions
    logic [G_W-1:0]            g_reg;
    logic [T_W-1:0]            r_old_reg;
    logic [T_W-1:0]            r_new_reg;
    logic [AV_W-1:0]           av_old_reg;
    logic [AV_W-1:0]           av_new_reg;
    logic                      hs1_en_reg;
    logic                      hs2_en_reg;
    logic                      end_sync_reg;
    logic [POS_WIDTH-1:0]      p_old_reg;
    logic [POS_WIDTH-1:0]      hs_old_reg;
    logic [POS_WIDTH-1:0]      p_new_reg;
    logic [POS_WIDTH-1:0]      hs_new_reg;

    // Output word
    logic                      gate_out_reg;
    logic                      start_out_reg;
    logic [POS_WIDTH-1:0]      pos_out_reg;
    logic [POS_WIDTH-1:0]      per_out_reg;

    // Prep signals
    logic                      sync;
    logic [BC_W-1:0]           hb_x100;
    logic [BC_W-1:0]           hb_x10;
    logic [BC_W-1:0]           eob_hi;
    logic [BC_W-1:0]           unit;
    logic [HB_W+BI_W-1:0]      hb_shift;
    logic [BI_W-1:0]           beat;
    logic                      eob_next;
    logic                      bar_par_next;
    logic [BI_W-1:0]           last_beat_next;
    logic [BPM_W-1:0]          diff;
    logic [DF_W-1:0]           diff_x;
    logic                      upd_sync;
    logic [BPM_W-1:0]          active_next;
    logic [BPM_W-1:0]          last_host_next;
    logic [tgc_pkg::MODE_W-1:0] last_mode_next;
    logic [T_W-1:0]            t_old;
    logic [T_W-1:0]            t_new;
    logic [DIV_W+T_W-1:0]      r_old_full;
    logic [DIV_W+T_W-1:0]      r_new_full;
    logic [AV_W-1:0]           av_old;
    logic [AV_W-1:0]           av_new;
    logic [SR_W+5:0]           sr60;
    logic [SR_W+6:0]           sr120;

    // Divider signals
    logic [G_W+T_W-1:0]        sync_prod;
    logic [NUM_W-1:0]          div_num;
    logic [AV_W-1:0]           div_den;
    logic [NUM_W-1:0]          quot;
    logic                      div_busy;
    logic [AV_W-1:0]           op_av;
    logic [QX_W-1:0]           qx;
    logic [POS_WIDTH-1:0]      q_cap;
    logic [POS_WIDTH-1:0]      per_res;
    logic [POS_WIDTH-1:0]      sync_res;

    // Finish signals
    logic [POS_WIDTH-1:0]      pos_a;
    logic [POS_WIDTH-1:0]      pos_b;
    logic [POS_WIDTH-1:0]      pcmp;
    logic [POS_WIDTH+1:0]      pos_x4;
    logic [POS_WIDTH+1:0]      pos_x2;
    logic [POS_WIDTH+1:0]      base_x;
    logic                      trig_in;
    logic                      gate_in;
    logic                      gate_fin;
    logic                      trig_fin;
    logic                      started;
    logic [POS_WIDTH-1:0]      pos_fin;
    logic [POS_WIDTH-1:0]      per_fin;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_rate_reg  <= tgc_pkg::SR_RESET;
            internal_bpm_reg <= tgc_pkg::IBPM_RESET;
            division_reg     <= tgc_pkg::DIV_RESET;
            sync_mode_reg    <= tgc_pkg::MODE_RESET;
        end
        else if (wr_en)
        begin
            unique case (tgc_pkg::reg_index_t'(wr_index))
                tgc_pkg::REG_SAMPLE_RATE:  sample_rate_reg  <= wr_data[SR_W-1:0];
                tgc_pkg::REG_INTERNAL_BPM: internal_bpm_reg <= wr_data[BPM_W-1:0];
                tgc_pkg::REG_DIVISION:     division_reg     <= wr_data[DIV_W-1:0];
                tgc_pkg::REG_SYNC_MODE:    sync_mode_reg    <= wr_data[tgc_pkg::MODE_W-1:0];
                default: ;
            endcase
        end
    end

    // Word capture
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            in_playing_reg <= playing;
            in_bpb_reg     <= beats_per_bar;
            in_hb_reg      <= host_bar_beat;
            in_hbpm_reg    <= host_bpm;
            in_close_reg   <= close_gate;
            in_clear_reg   <= clear_trigger;
        end
    end

    // Bar count and tempo follow
    always_comb
    begin
        sync    = sync_mode_reg != tgc_pkg::MODE_FREE;
        hb_x100 = BC_W'(in_hb_reg) * BC_W'(tgc_pkg::EOB_HI_DEN);
        hb_x10  = BC_W'(in_hb_reg) * BC_W'(tgc_pkg::EOB_LO_DEN);
        eob_hi  = BC_W'(tgc_pkg::EOB_HI_NUM) << BEAT_FRAC_BITS;
        unit    = BC_W'(1) << BEAT_FRAC_BITS;
        hb_shift = (HB_W+BI_W)'(in_hb_reg) >> BEAT_FRAC_BITS;
        beat    = hb_shift[BI_W-1:0];

        eob_next       = eob_reg;
        bar_par_next   = bar_par_reg;
        last_beat_next = last_beat_reg;
        if (in_bpb_reg <= tgc_pkg::BPB_W'(1))
        begin
            if (hb_x100 > eob_hi && !eob_reg)
                eob_next = 1'b1;
            else if (hb_x10 < unit && eob_reg)
            begin
                bar_par_next = ~bar_par_reg;
                eob_next     = 1'b0;
            end
        end
        else if (beat != last_beat_reg)
        begin
            if (beat == '0)
                bar_par_next = ~bar_par_reg;
            last_beat_next = beat;
        end

        diff = (in_hbpm_reg > last_host_bpm_reg) ? in_hbpm_reg - last_host_bpm_reg
                                                 : last_host_bpm_reg - in_hbpm_reg;
        diff_x = DF_W'(diff) * DF_W'(tgc_pkg::BPM_TOL_SCALE);
        upd_sync = (diff_x > (DF_W'(tgc_pkg::BPM_TOL) << BPM_FRAC_BITS))
                   || (sync_mode_reg != last_mode_reg);

        active_next    = active_bpm_reg;
        last_host_next = last_host_bpm_reg;
        last_mode_next = last_mode_reg;
        if (!sync)
        begin
            if (internal_bpm_reg != last_host_bpm_reg || sync_mode_reg != last_mode_reg)
            begin
                active_next    = internal_bpm_reg;
                last_mode_next = sync_mode_reg;
            end
        end
        else if (upd_sync)
        begin
            active_next    = in_hbpm_reg;
            last_host_next = in_hbpm_reg;
            last_mode_next = sync_mode_reg;
        end

        // Beat phase: only the low bar parity survives the mask
        t_old = T_W'(in_hb_reg) + {bar_par_reg & in_bpb_reg[0], {BEAT_FRAC_BITS{1'b0}}};
        t_new = T_W'(in_hb_reg) + {bar_par_next & in_bpb_reg[0], {BEAT_FRAC_BITS{1'b0}}};
        r_old_full = (DIV_W+T_W)'(division_reg) * (DIV_W+T_W)'(t_old);
        r_new_full = (DIV_W+T_W)'(division_reg) * (DIV_W+T_W)'(t_new);
        av_old = AV_W'(active_bpm_reg) * AV_W'(division_reg);
        av_new = AV_W'(active_next) * AV_W'(division_reg);
        sr60   = (SR_W+6)'(sample_rate_reg) * (SR_W+6)'(tgc_pkg::SR_BEAT_MULT);
        sr120  = (SR_W+7)'(sample_rate_reg) * (SR_W+7)'(tgc_pkg::SR_PERIOD_MULT);
    end

    // Prep registers
    always_ff @(posedge clk)
    begin
        if (cmd.prep)
        begin
            g_reg        <= {sr60, {BPM_FRAC_BITS{1'b0}}};
            r_old_reg    <= r_old_full[T_W-1:0];
            r_new_reg    <= r_new_full[T_W-1:0];
            av_old_reg   <= av_old;
            av_new_reg   <= av_new;
            hs1_en_reg   <= in_playing_reg && !was_playing_reg && sync;
            hs2_en_reg   <= sync && upd_sync && in_playing_reg;
            end_sync_reg <= in_playing_reg && sync;
        end
    end

    // Division operands
    always_comb
    begin
        sync_prod = '0;
        div_num   = '0;
        div_den   = '0;
        case (cmd.op)
            tgc_pkg::OP_PERIOD_OLD, tgc_pkg::OP_PERIOD_NEW:
            begin
                div_num = {sr120, {BPM_FRAC_BITS{1'b0}}};
            end
            tgc_pkg::OP_SYNC_OLD:
            begin
                sync_prod = (G_W+T_W)'(g_reg) * (G_W+T_W)'(r_old_reg);
                div_num   = sync_prod[G_W+T_W-1:BEAT_FRAC_BITS];
            end
            default:
            begin
                sync_prod = (G_W+T_W)'(g_reg) * (G_W+T_W)'(r_new_reg);
                div_num   = sync_prod[G_W+T_W-1:BEAT_FRAC_BITS];
            end
        endcase
        div_den = (cmd.op == tgc_pkg::OP_PERIOD_OLD || cmd.op == tgc_pkg::OP_SYNC_OLD)
                  ? av_old_reg : av_new_reg;
    end

    tgc_div #(
        .NUM_W (NUM_W),
        .DEN_W (AV_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.load),
        .num   (div_num),
        .den   (div_den),
        .busy  (div_busy),
        .quot  (quot)
    );

    assign status.div_busy = div_busy;

    // Quotient clean-up: saturation, zero tempo, zero rate
    always_comb
    begin
        op_av = div_den;
        qx    = QX_W'(quot);
        q_cap = (qx > QX_W'(POS_MAX)) ? POS_MAX : qx[POS_WIDTH-1:0];
        if (op_av == '0)
            per_res = POS_MAX;
        else if (q_cap == '0)
            per_res = POS_WIDTH'(1);
        else
            per_res = q_cap;
        sync_res = (op_av == '0) ? '0 : q_cap;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.store)
        begin
            case (cmd.op)
                tgc_pkg::OP_PERIOD_OLD: p_old_reg  <= per_res;
                tgc_pkg::OP_SYNC_OLD:   hs_old_reg <= sync_res;
                tgc_pkg::OP_PERIOD_NEW: p_new_reg  <= per_res;
                default:                hs_new_reg <= sync_res;
            endcase
        end
    end

    // Wrap, gate and trigger, final position
    always_comb
    begin
        pos_a = hs2_en_reg ? hs_new_reg : (hs1_en_reg ? hs_old_reg : position_reg);
        pcmp  = hs2_en_reg ? p_new_reg : p_old_reg;
        pos_b = (pos_a > pcmp) ? '0 : pos_a;
        pos_x4 = (POS_WIDTH+2)'(pos_b) << 2;
        pos_x2 = (POS_WIDTH+2)'(pos_b) << 1;
        base_x = (POS_WIDTH+2)'(p_old_reg);
        gate_in = gate_reg & ~in_close_reg;
        trig_in = trigger_reg & ~in_clear_reg;
        gate_fin = gate_in;
        trig_fin = trig_in;
        started  = 1'b0;
        if (pos_x4 < base_x && !trig_in)
        begin
            gate_fin = 1'b1;
            trig_fin = 1'b1;
            started  = 1'b1;
        end
        else if (pos_x2 > base_x && trig_in)
            trig_fin = 1'b0;
        pos_fin = end_sync_reg ? hs_new_reg : pos_b + POS_WIDTH'(1);
        per_fin = end_sync_reg ? p_new_reg : p_old_reg;
    end

    // State commit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg      <= '0;
            trigger_reg       <= 1'b0;
            gate_reg          <= 1'b0;
            eob_reg           <= 1'b0;
            was_playing_reg   <= 1'b0;
            last_beat_reg     <= '0;
            bar_par_reg       <= 1'b0;
            active_bpm_reg    <= tgc_pkg::ABPM_RESET;
            last_host_bpm_reg <= '0;
            last_mode_reg     <= '0;
        end
        else
        begin
            if (cmd.prep)
            begin
                was_playing_reg   <= in_playing_reg;
                eob_reg           <= eob_next;
                last_beat_reg     <= last_beat_next;
                bar_par_reg       <= bar_par_next;
                active_bpm_reg    <= active_next;
                last_host_bpm_reg <= last_host_next;
                last_mode_reg     <= last_mode_next;
            end
            if (cmd.finish)
            begin
                position_reg <= pos_fin;
                trigger_reg  <= trig_fin;
                gate_reg     <= gate_fin;
            end
        end
    end

    // Output word
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            gate_out_reg  <= gate_fin;
            start_out_reg <= started;
            pos_out_reg   <= pos_fin;
            per_out_reg   <= per_fin;
        end
    end

    assign gate       = gate_out_reg;
    assign gate_start = start_out_reg;
    assign position   = pos_out_reg;
    assign period     = per_out_reg;

endmodule

// ----- sv/tgc_ctrl.sv -----
// ---------------------------------------------------------------------------
// tgc_ctrl
// Sequencer: prep, four shared divisions, finish and output hand-off.
// ---------------------------------------------------------------------------
module tgc_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    output logic                 out_valid,
    input  logic                 out_stall,
    input  tgc_pkg::tgc_status_t status,
    output tgc_pkg::tgc_cmd_t    cmd
);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_PREP   = 6'b000010,
        ST_LOAD   = 6'b000100,
        ST_RUN    = 6'b001000,
        ST_STORE  = 6'b010000,
        ST_FINISH = 6'b100000
    } state_t;

    state_t           state_reg, state_next;
    tgc_pkg::div_op_t op_reg, op_next;
    logic             out_valid_reg;
    logic             fin_fire;

    assign fin_fire = (state_reg == ST_FINISH) && (!out_valid_reg || !out_stall);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        unique case (state_reg)
            ST_IDLE:
                if (in_valid)
                    state_next = ST_PREP;
            ST_PREP:
            begin
                op_next    = tgc_pkg::OP_PERIOD_OLD;
                state_next = ST_LOAD;
            end
            ST_LOAD:
                state_next = ST_RUN;
            ST_RUN:
                if (!status.div_busy)
                    state_next = ST_STORE;
            ST_STORE:
            begin
                if (op_reg == tgc_pkg::OP_SYNC_NEW)
                    state_next = ST_FINISH;
                else
                begin
                    op_next    = tgc_pkg::div_op_t'(op_reg + 2'd1);
                    state_next = ST_LOAD;
                end
            end
            ST_FINISH:
                if (fin_fire)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            op_reg        <= tgc_pkg::OP_PERIOD_OLD;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            if (fin_fire)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Commands
    always_comb
    begin
        cmd.capture = (state_reg == ST_IDLE) && in_valid;
        cmd.prep    = state_reg == ST_PREP;
        cmd.load    = state_reg == ST_LOAD;
        cmd.op      = op_reg;
        cmd.store   = state_reg == ST_STORE;
        cmd.finish  = fin_fire;
    end

    assign in_stall  = state_reg != ST_IDLE;
    assign out_valid = out_valid_reg;

`include "tempo_gate_clock_macros.svh"

    `TGC_ASSERT_NEXT(a_acc_prep, clk, rst_n, in_valid && !in_stall, state_reg == ST_PREP, "no prep")
    `TGC_ASSERT_NEXT(a_fin_out, clk, rst_n, fin_fire, out_valid_reg && state_reg == ST_IDLE, "no out")
    `TGC_ASSERT_ALWAYS(a_busy_run, clk, rst_n, !status.div_busy || state_reg == ST_RUN, "busy off run")

endmodule

// ----- sv/tempo_gate_clock.sv -----
// ---------------------------------------------------------------------------
// tempo_gate_clock
// Sample-tick tempo clock with gate and trigger, synced to host transport.
//
//   channel  direction  handshake            fields
//   in       sink       in_valid / in_stall  playing .. clear_trigger
//   out      source     out_valid/out_stall  gate, gate_start, position, period
//   config   sink       wr_en                wr_index, wr_data
//
// A word's result is registered once the four divisions, which share one
// bit-per-cycle restoring divider, are done; the next word can be taken in
// the cycle after that.
// Reset is asynchronous, active low, and needs no clearing pass.
// A result waits in the output register; a stalled output holds the
// sequencer at its finish step only.
// ---------------------------------------------------------------------------
module tempo_gate_clock #(
    parameter int BEAT_FRAC_BITS = tgc_pkg::BEAT_FRAC_BITS_DEF,
    parameter int BPM_FRAC_BITS  = tgc_pkg::BPM_FRAC_BITS_DEF,
    parameter int POS_WIDTH      = tgc_pkg::POS_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          wr_en,
    input  logic [tgc_pkg::CFG_IDX_W-1:0] wr_index,
    input  logic [tgc_pkg::CFG_W-1:0]     wr_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          playing,
    input  logic [tgc_pkg::BPB_W-1:0]     beats_per_bar,
    input  logic [tgc_pkg::HB_W-1:0]      host_bar_beat,
    input  logic [tgc_pkg::BPM_W-1:0]     host_bpm,
    input  logic                          close_gate,
    input  logic                          clear_trigger,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          gate,
    output logic                          gate_start,
    output logic [POS_WIDTH-1:0]          position,
    output logic [POS_WIDTH-1:0]          period
);

    tgc_pkg::tgc_cmd_t    cmd;
    tgc_pkg::tgc_status_t status;

    tgc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    tgc_datapath #(
        .BEAT_FRAC_BITS (BEAT_FRAC_BITS),
        .BPM_FRAC_BITS  (BPM_FRAC_BITS),
        .POS_WIDTH      (POS_WIDTH)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .wr_en         (wr_en),
        .wr_index      (wr_index),
        .wr_data       (wr_data),
        .playing       (playing),
        .beats_per_bar (beats_per_bar),
        .host_bar_beat (host_bar_beat),
        .host_bpm      (host_bpm),
        .close_gate    (close_gate),
        .clear_trigger (clear_trigger),
        .gate          (gate),
        .gate_start    (gate_start),
        .position      (position),
        .period        (period)
    );

endmodule
